// ===== hw/rtl/exp_kernel_spike_train_norm_top_defines.svh =====
// Assertion macros for the spike-train markage block.
// Used by the port-level checker; no other dependencies.
`ifndef EXP_KERNEL_SPIKE_TRAIN_NORM_TOP_DEFINES_SVH
`define EXP_KERNEL_SPIKE_TRAIN_NORM_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define EKST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ekst assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define EKST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ekst assertion failed");

`endif

// ===== hw/rtl/ekst_pkg.sv =====
// Shared types and constants for the spike-train markage block.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package ekst_pkg;

  // Configuration register indexes
  localparam logic CFG_DECAY_RATE = 1'b0;
  localparam logic CFG_TAU_ZERO   = 1'b1;

  localparam logic [31:0] RATE_RESET = 32'd65536;
  localparam logic [32:0] ONE_Q16    = 33'd65536;
  localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [47:0] MAX48      = 48'hFFFF_FFFF_FFFF;
  localparam logic [5:0]  SHIFT_LIMIT = 6'd40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_LUT,
    ST_INTERP,
    ST_MARK,
    ST_ACC,
    ST_OUT
  } ekst_state_e;

  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic lut;
    logic interp;
    logic mark;
    logic acc;
    logic load_out;
  } ekst_cmd_t;

  typedef struct packed {
    logic out_busy;
  } ekst_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ekst_ctrl.sv =====
// Sequencer for the markage datapath: one beat at a time through the steps.
// Depends on ekst_pkg.
`default_nettype none

module ekst_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire ekst_pkg::ekst_status_t status_i,
  output ekst_pkg::ekst_cmd_t        cmd_o
);

  ekst_pkg::ekst_state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ekst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance through the steps, wait at the end for a free output register
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ekst_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ekst_pkg::ST_MUL1;
        end
      end
      ekst_pkg::ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ekst_pkg::ST_MUL2;
      end
      ekst_pkg::ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ekst_pkg::ST_LUT;
      end
      ekst_pkg::ST_LUT: begin
        cmd_o.lut = 1'b1;
        state_d   = ekst_pkg::ST_INTERP;
      end
      ekst_pkg::ST_INTERP: begin
        cmd_o.interp = 1'b1;
        state_d      = ekst_pkg::ST_MARK;
      end
      ekst_pkg::ST_MARK: begin
        cmd_o.mark = 1'b1;
        state_d    = ekst_pkg::ST_ACC;
      end
      ekst_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = ekst_pkg::ST_OUT;
      end
      ekst_pkg::ST_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ekst_pkg::ST_IDLE;
        end
      end
      default: state_d = ekst_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ekst_datapath.sv =====
// Datapath: decay evaluation, markage recursion, running norm, output register.
// Depends on ekst_pkg; driven by ekst_ctrl commands.
`default_nettype none

module ekst_datapath #(
  parameter int EXP_TABLE_ENTRIES = 256,
  parameter int COUNT_BITS        = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [31:0]           cfg_data_i,
  input  wire logic [31:0]           spike_time_i,
  input  wire logic                  first_spike_i,
  input  wire logic                  last_spike_i,
  input  wire ekst_pkg::ekst_cmd_t   cmd_i,
  output ekst_pkg::ekst_status_t     status_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [31:0]                markage_value_o,
  output logic [47:0]                norm_so_far_o,
  output logic [15:0]                spikes_seen_o,
  output logic                       train_done_o
);

  localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int POS_W = 46 + IDX_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(EXP_TABLE_ENTRIES - 1);

  typedef logic [32:0] pow_tbl_t [EXP_TABLE_ENTRIES+1];

  // 2^-(k/N) in Q.32 from the alternating series of exp(-z)
  function automatic pow_tbl_t build_pow_tbl();
    pow_tbl_t    tbl;
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] plus;
    logic [63:0] minus;
    for (int k = 0; k <= EXP_TABLE_ENTRIES; k++) begin
      z     = (64'(k) * 64'(ekst_pkg::LN2_Q32)) / EXP_TABLE_ENTRIES;
      term  = 64'd1 << 32;
      plus  = term;
      minus = '0;
      for (int i = 1; i <= 24; i++) begin
        term = ((term * z) >> 32) / 64'(i);
        if (i % 2 == 1) minus = minus + term;
        else            plus  = plus + term;
      end
      tbl[k] = (plus >= minus) ? 33'(plus - minus) : 33'd0;
    end
    tbl[0] = 33'h1_0000_0000;
    return tbl;
  endfunction

  localparam pow_tbl_t POW_TBL = build_pow_tbl();

  // Configuration
  logic [31:0] rate_q;
  logic        tau_zero_q;

  // Train state
  logic [31:0]           prev_time_q;
  logic [31:0]           prev_mark_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [47:0]           total_q;

  // Per-beat working registers
  logic [31:0] time_q, dt_q;
  logic        start_q, last_q;
  logic [63:0] p_q;
  logic        big_q;
  logic [51:0] y_q;
  logic [5:0]  n_q;
  logic [15:0] r_q;
  logic [32:0] lo_q, hi_q;
  logic [32:0] decay_q;
  logic [31:0] mark_q;
  logic        out_valid_q;

  // Table lookup position
  logic [POS_W-1:0] pos;
  logic [IDX_W-1:0] idx_raw, idx;
  assign pos     = POS_W'(y_q[45:0]) * POS_W'(EXP_TABLE_ENTRIES);
  assign idx_raw = pos[POS_W-1:46];
  assign idx     = (idx_raw > IDX_LAST) ? IDX_LAST : idx_raw;

  // Interpolate between neighboring points, then apply the integer power
  logic [48:0] step;
  logic [32:0] interp;
  assign step   = 49'(lo_q - hi_q) * 49'(r_q);
  assign interp = (lo_q >= hi_q) ? (lo_q - step[48:16]) : lo_q;

  // Markage product (prev + 1.0) * decay
  logic [32:0] a;
  logic [65:0] prod;
  logic [31:0] mark_d;
  assign a      = 33'(prev_mark_q) + ekst_pkg::ONE_Q16;
  assign prod   = 66'(a) * 66'(decay_q);
  assign mark_d = (start_q || tau_zero_q) ? 32'd0 :
                  (prod[65:64] != 2'd0) ? 32'hFFFF_FFFF : prod[63:32];

  // Saturating accumulate
  logic [48:0] total_sum;
  assign total_sum = 49'(total_q) + 49'(mark_q);

  // Norm: count + 2 * total
  logic [49:0] norm_sum;
  assign norm_sum = 50'({count_q, 16'h0000}) + 50'({total_q, 1'b0});

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q     <= ekst_pkg::RATE_RESET;
      tau_zero_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ekst_pkg::CFG_DECAY_RATE: rate_q     <= cfg_data_i;
        ekst_pkg::CFG_TAU_ZERO:   tau_zero_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Train state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= '0;
      prev_mark_q <= '0;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc) begin
        prev_time_q <= time_q;
        prev_mark_q <= mark_q;
        if (start_q) begin
          count_q <= COUNT_BITS'(1);
          total_q <= '0;
        end else begin
          if (count_q != COUNT_MAX) count_q <= count_q + 1'b1;
          total_q <= total_sum[48] ? ekst_pkg::MAX48 : total_sum[47:0];
        end
      end
      // Close the train after its last beat is posted
      if (cmd_i.load_out && last_q) begin
        count_q <= '0;
        total_q <= '0;
      end
      if (cmd_i.load_out)                 out_valid_q <= 1'b1;
      else if (out_ready_i)               out_valid_q <= 1'b0;
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      time_q  <= spike_time_i;
      dt_q    <= (spike_time_i >= prev_time_q) ? (spike_time_i - prev_time_q) : 32'd0;
      start_q <= first_spike_i || (count_q == '0);
      last_q  <= last_spike_i;
    end
    if (cmd_i.mul1) p_q <= 64'(dt_q) * 64'(rate_q);
    if (cmd_i.mul2) begin
      big_q <= (p_q[63:37] != '0);
      y_q   <= 52'(p_q[36:16]) * 52'(ekst_pkg::LOG2E_Q30);
    end
    if (cmd_i.lut) begin
      n_q  <= y_q[51:46];
      r_q  <= pos[45:30];
      lo_q <= POW_TBL[idx];
      hi_q <= POW_TBL[idx + 1'b1];
    end
    if (cmd_i.interp) begin
      decay_q <= (big_q || n_q >= ekst_pkg::SHIFT_LIMIT) ? 33'd0 : (interp >> n_q);
    end
    if (cmd_i.mark) mark_q <= mark_d;
    if (cmd_i.load_out) begin
      markage_value_o <= prev_mark_q;
      norm_so_far_o   <= (norm_sum > 50'(ekst_pkg::MAX48)) ? ekst_pkg::MAX48
                                                            : norm_sum[47:0];
      spikes_seen_o   <= (32'(count_q) > 32'd65535) ? 16'hFFFF : 16'(count_q);
      train_done_o    <= last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire

// ===== hw/rtl/exp_kernel_spike_train_norm_top.sv =====
// One input beat at a time: a new beat is taken only once the last result is loaded.
// The markage recursion sets this: each beat runs the multiply
// sequencer (rate, log2e, table interpolation, markage) before the next.
// A waiting result holds the sequencer at its last step until taken.
// Reset (rst_ni low, asynchronous): decay_rate 1.0, tau_zero_mode 0, no open train.
`default_nettype none

module exp_kernel_spike_train_norm_top #(
  parameter int EXP_TABLE_ENTRIES = 256,
  parameter int COUNT_BITS        = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] spike_time_i,
  input  wire logic        first_spike_i,
  input  wire logic        last_spike_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      markage_value_o,
  output logic [47:0]      norm_so_far_o,
  output logic [15:0]      spikes_seen_o,
  output logic             train_done_o
);

  ekst_pkg::ekst_cmd_t    cmd;
  ekst_pkg::ekst_status_t status;

  // Step sequencer
  ekst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and state
  ekst_datapath #(
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES),
    .COUNT_BITS        (COUNT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .spike_time_i    (spike_time_i),
    .first_spike_i   (first_spike_i),
    .last_spike_i    (last_spike_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .markage_value_o (markage_value_o),
    .norm_so_far_o   (norm_so_far_o),
    .spikes_seen_o   (spikes_seen_o),
    .train_done_o    (train_done_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ekst_checker.sv =====
// Port-level checker for the spike-train markage block, bound to the top level.
// Depends on exp_kernel_spike_train_norm_top_defines.svh.
`default_nettype none
`include "exp_kernel_spike_train_norm_top_defines.svh"

module ekst_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] markage_value_o,
  input wire logic [47:0] norm_so_far_o,
  input wire logic [15:0] spikes_seen_o
);

  // Result beat holds until taken
  `EKST_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  // Sequencer is busy right after taking a beat
  `EKST_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  // Every result belongs to an open train
  `EKST_ASSERT_IMP(a_count_nonzero, out_valid_o, spikes_seen_o != 16'd0)
  // The opening spike has zero markage and a norm of exactly one
  `EKST_ASSERT_IMP(a_first_spike, out_valid_o && spikes_seen_o == 16'd1,
                   markage_value_o == 32'd0 && norm_so_far_o == 48'd65536)

endmodule

bind exp_kernel_spike_train_norm_top ekst_checker u_ekst_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_exp_kernel_spike_train_norm_top.sv =====
// Testbench for exp_kernel_spike_train_norm_top: spike beats go in, markage results are
// checked against an in-bench markage/norm predictor. Depends on ekst_pkg and the top level.
`timescale 1ns / 100ps
`default_nettype none

module tb_exp_kernel_spike_train_norm_top;

  localparam int TABLE_PTS   = 256;
  localparam int COUNT_W     = 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam longint unsigned LOG2E  = 64'd1549082005;
  localparam longint unsigned LN2    = 64'd2977044472;
  localparam longint unsigned FRAC46 = (64'd1 << 46) - 1;
  localparam longint unsigned SAT48  = (64'd1 << 48) - 1;
  localparam longint unsigned CNT_MAX = (64'd1 << COUNT_W) - 1;

  typedef struct {
    logic [31:0] markage;
    logic [47:0] norm;
    logic [15:0] seen;
    logic        done;
  } markage_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] spike_time_i = '0;
  logic        first_spike_i = 1'b0;
  logic        last_spike_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] markage_value_o;
  logic [47:0] norm_so_far_o;
  logic [15:0] spikes_seen_o;
  logic        train_done_o;

  exp_kernel_spike_train_norm_top u_dut (.*);

  // Predictor state and configuration
  longint unsigned pow2_table [TABLE_PTS+1];
  logic [31:0]     rate_q16 = 32'd65536;
  logic            tau_zero = 1'b0;
  logic [31:0]     last_time = '0;
  logic [31:0]     last_mark = '0;
  longint unsigned train_count = 0;
  longint unsigned mark_sum = 0;

  markage_result_t pending_results[$];
  int  err_count = 0;
  int  snd_idle = 0;
  int  rcv_idle = 0;
  int  hold_cycles = 0;
  longint cycle_count = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Abort on runaway
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // 2^-(k/N) in Q.32 through the alternating exp series
  function automatic longint unsigned pow2_point(longint unsigned k);
    longint unsigned z, term, plus, minus;
    z = (k * LN2) / TABLE_PTS;
    term = 64'd1 << 32;
    plus = term;
    minus = 0;
    for (int i = 1; i <= 24; i++) begin
      term = ((term * z) >> 32) / i;
      if (i % 2) minus += term;
      else plus += term;
    end
    return (plus >= minus) ? plus - minus : 0;
  endfunction

  // Decay factor in Q.32 for a gap in Q16.16
  function automatic longint unsigned decay_factor(logic [31:0] gap);
    longint unsigned p, y, n, f, pos, idx, r, lo, hi, d;
    p = longint'(gap) * longint'(rate_q16);
    if (p >= (64'd32 << 32)) return 0;
    y = (p >> 16) * LOG2E;
    n = y >> 46;
    f = y & FRAC46;
    pos = f * TABLE_PTS;
    idx = pos >> 46;
    if (idx >= TABLE_PTS) idx = TABLE_PTS - 1;
    r = (pos & FRAC46) >> 30;
    lo = pow2_table[idx];
    hi = pow2_table[idx+1];
    d = (lo >= hi) ? lo - (((lo - hi) * r) >> 16) : lo;
    if (n >= 40) return 0;
    return d >> n;
  endfunction

  // Advance the train state by one spike and queue its result
  task automatic predict_markage(logic [31:0] t, logic first, logic last);
    longint unsigned m, d, a, norm;
    markage_result_t res;
    m = 0;
    if (first || train_count == 0) begin
      train_count = 1;
      mark_sum = 0;
    end else begin
      if (!tau_zero) begin
        d = decay_factor((t >= last_time) ? t - last_time : 32'd0);
        a = longint'(last_mark) + 64'd65536;
        m = (a * (d >> 16) + ((a * (d & 64'hFFFF)) >> 16)) >> 16;
        if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
      end
      if (train_count < CNT_MAX) train_count++;
      mark_sum += m;
      if (mark_sum > SAT48) mark_sum = SAT48;
    end
    last_time = t;
    last_mark = m[31:0];
    norm = (train_count << 16) + 2 * mark_sum;
    if (norm > SAT48) norm = SAT48;
    res.markage = m[31:0];
    res.norm = norm[47:0];
    res.seen = (train_count > 65535) ? 16'hFFFF : train_count[15:0];
    res.done = last;
    pending_results.push_back(res);
    if (last) begin
      train_count = 0;
      mark_sum = 0;
    end
  endtask

  // Send one spike beat, with random idle before it
  task automatic send_spike(logic [31:0] t, logic first, logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    spike_time_i <= t;
    first_spike_i <= first;
    last_spike_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_markage(t, first, last);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Wait until every result is back, plus pipeline slack
  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ekst_pkg::CFG_DECAY_RATE) rate_q16 = data;
    else tau_zero = data[0];
  endtask

  // Receiver: random stall, or hold off while hold_cycles runs down
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    markage_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat");
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (markage_value_o !== exp_r.markage) begin
          $error("markage_value exp %h got %h", exp_r.markage, markage_value_o);
          err_count++;
        end
        if (norm_so_far_o !== exp_r.norm) begin
          $error("norm_so_far exp %h got %h", exp_r.norm, norm_so_far_o);
          err_count++;
        end
        if (spikes_seen_o !== exp_r.seen) begin
          $error("spikes_seen exp %0d got %0d", exp_r.seen, spikes_seen_o);
          err_count++;
        end
        if (train_done_o !== exp_r.done) begin
          $error("train_done exp %0b got %0b", exp_r.done, train_done_o);
          err_count++;
        end
      end
    end
  end

  // Random train: mostly well-formed, some noise flags and backward steps
  task automatic send_train(output int n_spikes);
    int len;
    logic [31:0] t;
    len = $urandom_range(1, 8);
    t = $urandom;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) t = $urandom;
      else if (i > 0) t = t + $urandom_range(0, 32'h3_0000);
      if ($urandom_range(19) == 0)
        send_spike(t, $urandom_range(1), $urandom_range(1));
      else
        send_spike(t, i == 0, i == len - 1);
    end
    n_spikes = len;
  endtask

  task automatic test_directed();
    send_spike(32'h0, 1'b1, 1'b0);
    send_spike(32'h0, 1'b0, 1'b0);
    send_spike(32'h0001_0000, 1'b0, 1'b0);
    send_spike(32'h0000_8000, 1'b0, 1'b0);        // time going backwards
    send_spike(32'hFFFF_FFFF, 1'b0, 1'b1);        // huge gap, closes train
    send_spike(32'hFFFF_FFFF, 1'b0, 1'b0);        // opens train without first flag
    send_spike(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_spike(32'h1234_5678, 1'b1, 1'b0);        // restart mid-train
    send_spike(32'h1234_9000, 1'b1, 1'b1);        // single-spike train
    send_spike(32'h5555_5555, 1'b0, 1'b0);
    send_spike(32'hAAAA_AAAA, 1'b0, 1'b1);
    drain_results();
    write_cfg(ekst_pkg::CFG_TAU_ZERO, 32'd1);
    send_spike(32'h10, 1'b1, 1'b0);
    send_spike(32'h20, 1'b0, 1'b0);
    send_spike(32'h30, 1'b0, 1'b1);
    drain_results();
    write_cfg(ekst_pkg::CFG_TAU_ZERO, 32'd0);
    write_cfg(ekst_pkg::CFG_DECAY_RATE, 32'd0);   // infinite tau: decay of one
    for (int i = 0; i < 6; i++) send_spike(32'h100 * i, i == 0, i == 5);
    drain_results();
    write_cfg(ekst_pkg::CFG_DECAY_RATE, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send_spike(i, i == 0, i == 3);
    drain_results();
  endtask

  task automatic test_random_phase(int s_idle, int r_idle, int n_items);
    int sent;
    int n_train;
    snd_idle = s_idle;
    rcv_idle = r_idle;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(29) == 0) begin
        drain_results();
        case ($urandom_range(3))
          0: write_cfg(ekst_pkg::CFG_DECAY_RATE, $urandom);
          1: write_cfg(ekst_pkg::CFG_DECAY_RATE, $urandom_range(0, 32'h4_0000));
          2: write_cfg(ekst_pkg::CFG_DECAY_RATE, 32'd1);
          default: write_cfg(ekst_pkg::CFG_TAU_ZERO, $urandom_range(1));
        endcase
      end
      send_train(n_train);
      sent = sent + n_train;
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    snd_idle = 0;
    rcv_idle = 0;
    write_cfg(ekst_pkg::CFG_TAU_ZERO, 32'd0);
    write_cfg(ekst_pkg::CFG_DECAY_RATE, 32'h0000_8000);
    @(negedge clk_i);
    hold_cycles = 300;
    for (int i = 0; i < 10; i++) send_spike(32'h1000 * i, i == 0, i == 9);
    drain_results();
  endtask

  initial begin
    for (int k = 0; k <= TABLE_PTS; k++) pow2_table[k] = pow2_point(k);
    pow2_table[0] = 64'd1 << 32;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_phase(34, 50, 300);
    test_random_phase(50, 34, 300);
    test_random_phase(0, 0, 300);
    test_backpressure();

    drain_results();
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
